[rtl/core/qwvs_pkg.sv]
// Shared constants, codes and table entry types for the vertex skinning unit.
package qwvs_pkg;

	localparam int MAX_JOINTS = 64;
	localparam int MAX_WEIGHTS = 1024;
	localparam int MAX_PER_VERTEX = 16;

	localparam int JIDX_W = $clog2(MAX_JOINTS);
	localparam int WIDX_W = $clog2(MAX_WEIGHTS);
	localparam int CNT_W = $clog2(MAX_PER_VERTEX + 1);

	localparam logic [1:0] FN_LOAD_JOINT = 2'd0;
	localparam logic [1:0] FN_LOAD_WEIGHT = 2'd1;
	localparam logic [1:0] FN_COMPUTE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef struct packed {
		logic signed [15:0] qw;
		logic signed [15:0] qz;
		logic signed [15:0] qy;
		logic signed [15:0] qx;
		logic signed [31:0] pz;
		logic signed [31:0] py;
		logic signed [31:0] px;
	} joint_t;

	typedef struct packed {
		logic [5:0] joint;
		logic [15:0] bias;
		logic signed [31:0] oz;
		logic signed [31:0] oy;
		logic signed [31:0] ox;
	} weight_t;

endpackage

[rtl/core/qwvs_if.sv]
// Request and result channel interfaces of the vertex skinning unit.
interface qwvs_req_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [9:0] slot;
	logic [5:0] joint_ref;
	logic [15:0] bias;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] rot_x;
	logic signed [15:0] rot_y;
	logic signed [15:0] rot_z;
	logic [4:0] weight_count;

	modport source (output valid, func, slot, joint_ref, bias, pos_x, pos_y, pos_z,
		rot_x, rot_y, rot_z, weight_count, input ready);
	modport sink (input valid, func, slot, joint_ref, bias, pos_x, pos_y, pos_z,
		rot_x, rot_y, rot_z, weight_count, output ready);
endinterface

interface qwvs_rsp_if;
	logic valid;
	logic ready;
	logic signed [31:0] skin_x;
	logic signed [31:0] skin_y;
	logic signed [31:0] skin_z;
	logic [1:0] status;

	modport source (output valid, skin_x, skin_y, skin_z, status, input ready);
	modport sink (input valid, skin_x, skin_y, skin_z, status, output ready);
endinterface

[rtl/core/qwvs_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module qwvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[rtl/core/qwvs_isqrt.sv]
// Iterative integer square root, two radicand bits per cycle.
module qwvs_isqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [30:0] radicand,
	output logic done,
	output logic [15:0] root
);
	logic [31:0] rad_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [3:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [19:0] rem_n;
	logic [19:0] trial;
	logic fits;

	assign rem_n = {rem_q, rad_q[31:30]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= {1'b0, radicand};
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[29:0], 2'b00};
			if (fits) begin
				rem_q <= 18'(rem_n - trial);
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_n[17:0];
				root_q <= {root_q[14:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

[rtl/core/quaternion_weighted_vertex_skinning_unit.sv]
// Top level of the quaternion weighted vertex skinning unit.
// A weight load is written when it is accepted; a joint load runs the square sum, a 16-step root
// and the write, or goes from the square sum straight to the write if no root is left to take.
// Each weight of a compute request runs through states WRD, JRD, MUL1, C1, MUL2, RSUM, BIAS, ACC.
// One request is worked at a time; a finished result waits in the output register.
// Reset clears control state only; table entries read as unknown until loaded.
module quaternion_weighted_vertex_skinning_unit (
	input logic clk,
	input logic arst_n,
	qwvs_req_if.sink req,
	qwvs_rsp_if.source rsp
);
	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_TSUM = 12'b000000000010,
		S_SQRT = 12'b000000000100,
		S_WRD  = 12'b000000001000,
		S_JRD  = 12'b000000010000,
		S_MUL1 = 12'b000000100000,
		S_C1   = 12'b000001000000,
		S_MUL2 = 12'b000010000000,
		S_RSUM = 12'b000100000000,
		S_BIAS = 12'b001000000000,
		S_ACC  = 12'b010000000000,
		S_DONE = 12'b100000000000
	} state_t;

	localparam logic [qwvs_pkg::CNT_W-1:0] CNT_ONE = qwvs_pkg::CNT_W'(1);

	state_t state_q;
	logic accept;
	logic err_q;
	logic [qwvs_pkg::CNT_W-1:0] cnt_q;
	logic [qwvs_pkg::WIDX_W-1:0] widx_q;
	logic [qwvs_pkg::JIDX_W-1:0] jslot_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [15:0] rx_q, ry_q, rz_q;
	logic [31:0] sq_s1 [3];
	logic signed [32:0] t_val;

	logic sqrt_start;
	logic sqrt_done;
	logic [15:0] sqrt_root;

	logic jram_we, jram_re, wram_we, wram_re;
	qwvs_pkg::joint_t jwdata, jdat;
	qwvs_pkg::weight_t wwdata, wdat;
	logic [qwvs_pkg::JIDX_W-1:0] jraddr;

	logic signed [47:0] m_s1 [6];
	logic signed [34:0] c1_s2 [3];
	logic signed [50:0] wc_s3 [3];
	logic signed [50:0] ca_s3 [3];
	logic signed [50:0] cb_s3 [3];
	logic signed [41:0] p_s4 [3];
	logic signed [58:0] bp_s5 [3];
	logic signed [49:0] acc_q [3];

	logic rsp_valid_q;
	logic signed [31:0] sx_q, sy_q, sz_q;
	logic [1:0] status_q;
	logic out_free;
	logic bad_req;
	logic [10:0] range_end;
	logic signed [31:0] sat_val [3];
	logic [2:0] sat_hit;

	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	assign range_end = 11'(req.slot) + 11'(req.weight_count);
	assign bad_req = (int'(req.weight_count) > qwvs_pkg::MAX_PER_VERTEX)
		|| (int'(range_end) > qwvs_pkg::MAX_WEIGHTS);

	assign t_val = 33'sd1073741824 - $signed({1'b0, sq_s1[0]})
		- $signed({1'b0, sq_s1[1]}) - $signed({1'b0, sq_s1[2]});

	qwvs_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(sqrt_start),
		.radicand(t_val[30:0]),
		.done(sqrt_done),
		.root(sqrt_root)
	);

	assign sqrt_start = (state_q == S_TSUM) && !t_val[32];
	assign jram_we = ((state_q == S_TSUM) && t_val[32]) || ((state_q == S_SQRT) && sqrt_done);
	assign jwdata.qx = rx_q;
	assign jwdata.qy = ry_q;
	assign jwdata.qz = rz_q;
	assign jwdata.qw = (state_q == S_SQRT) ? 16'(17'd0 - {1'b0, sqrt_root}) : 16'sd0;
	assign jwdata.px = px_q;
	assign jwdata.py = py_q;
	assign jwdata.pz = pz_q;
	assign jram_re = (state_q == S_JRD);
	assign jraddr = qwvs_pkg::JIDX_W'(wdat.joint);

	qwvs_ram #(.WIDTH($bits(qwvs_pkg::joint_t)), .DEPTH(qwvs_pkg::MAX_JOINTS)) u_jram (
		.clk(clk),
		.we(jram_we),
		.waddr(jslot_q),
		.wdata(jwdata),
		.re(jram_re),
		.raddr(jraddr),
		.rdata(jdat)
	);

	assign wram_we = accept && (req.func == qwvs_pkg::FN_LOAD_WEIGHT)
		&& (int'(req.slot) < qwvs_pkg::MAX_WEIGHTS);
	assign wwdata.joint = req.joint_ref;
	assign wwdata.bias = req.bias;
	assign wwdata.ox = req.pos_x;
	assign wwdata.oy = req.pos_y;
	assign wwdata.oz = req.pos_z;
	assign wram_re = (state_q == S_WRD);

	qwvs_ram #(.WIDTH($bits(qwvs_pkg::weight_t)), .DEPTH(qwvs_pkg::MAX_WEIGHTS)) u_wram (
		.clk(clk),
		.we(wram_we),
		.waddr(qwvs_pkg::WIDX_W'(req.slot)),
		.wdata(wwdata),
		.re(wram_re),
		.raddr(widx_q),
		.rdata(wdat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			err_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.func == qwvs_pkg::FN_LOAD_JOINT
							&& int'(req.slot) < qwvs_pkg::MAX_JOINTS) begin
							state_q <= S_TSUM;
						end else if (req.func == qwvs_pkg::FN_COMPUTE) begin
							err_q <= bad_req;
							if (bad_req || req.weight_count == 5'd0) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_WRD;
							end
						end
					end
				end
				S_TSUM: state_q <= t_val[32] ? S_IDLE : S_SQRT;
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_IDLE;
					end
				end
				S_WRD: state_q <= S_JRD;
				S_JRD: begin
					if (int'(wdat.joint) >= qwvs_pkg::MAX_JOINTS) begin
						err_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_C1;
				S_C1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_RSUM;
				S_RSUM: state_q <= S_BIAS;
				S_BIAS: state_q <= S_ACC;
				S_ACC: state_q <= (cnt_q == CNT_ONE) ? S_DONE : S_WRD;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			jslot_q <= qwvs_pkg::JIDX_W'(req.slot);
			widx_q <= qwvs_pkg::WIDX_W'(req.slot);
			cnt_q <= qwvs_pkg::CNT_W'(req.weight_count);
			px_q <= req.pos_x;
			py_q <= req.pos_y;
			pz_q <= req.pos_z;
			rx_q <= req.rot_x;
			ry_q <= req.rot_y;
			rz_q <= req.rot_z;
			sq_s1[0] <= 32'(req.rot_x * req.rot_x);
			sq_s1[1] <= 32'(req.rot_y * req.rot_y);
			sq_s1[2] <= 32'(req.rot_z * req.rot_z);
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= '0;
			end
		end
		if (state_q == S_MUL1) begin
			m_s1[0] <= jdat.qy * wdat.oz;
			m_s1[1] <= jdat.qz * wdat.oy;
			m_s1[2] <= jdat.qz * wdat.ox;
			m_s1[3] <= jdat.qx * wdat.oz;
			m_s1[4] <= jdat.qx * wdat.oy;
			m_s1[5] <= jdat.qy * wdat.ox;
		end
		if (state_q == S_C1) begin
			for (int k = 0; k < 3; k++) begin
				c1_s2[k] <= 35'((50'(m_s1[2*k]) - 50'(m_s1[2*k+1]) + 50'sd16384) >>> 15);
			end
		end
		if (state_q == S_MUL2) begin
			for (int k = 0; k < 3; k++) begin
				wc_s3[k] <= jdat.qw * c1_s2[k];
			end
			ca_s3[0] <= jdat.qy * c1_s2[2];
			cb_s3[0] <= jdat.qz * c1_s2[1];
			ca_s3[1] <= jdat.qz * c1_s2[0];
			cb_s3[1] <= jdat.qx * c1_s2[2];
			ca_s3[2] <= jdat.qx * c1_s2[1];
			cb_s3[2] <= jdat.qy * c1_s2[0];
		end
		if (state_q == S_RSUM) begin
			p_s4[0] <= 42'(jdat.px) + 42'(wdat.ox) + 42'((54'(wc_s3[0]) + 54'(ca_s3[0])
				- 54'(cb_s3[0]) + 54'sd8192) >>> 14);
			p_s4[1] <= 42'(jdat.py) + 42'(wdat.oy) + 42'((54'(wc_s3[1]) + 54'(ca_s3[1])
				- 54'(cb_s3[1]) + 54'sd8192) >>> 14);
			p_s4[2] <= 42'(jdat.pz) + 42'(wdat.oz) + 42'((54'(wc_s3[2]) + 54'(ca_s3[2])
				- 54'(cb_s3[2]) + 54'sd8192) >>> 14);
		end
		if (state_q == S_BIAS) begin
			for (int k = 0; k < 3; k++) begin
				bp_s5[k] <= p_s4[k] * $signed({1'b0, wdat.bias});
			end
		end
		if (state_q == S_ACC) begin
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= acc_q[k] + 50'((60'(bp_s5[k]) + 60'sd16384) >>> 15);
			end
			cnt_q <= cnt_q - CNT_ONE;
			widx_q <= widx_q + qwvs_pkg::WIDX_W'(1);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (acc_q[k] > 50'sd2147483647) begin
				sat_val[k] = 32'sh7FFFFFFF;
				sat_hit[k] = 1'b1;
			end else if (acc_q[k] < -50'sd2147483648) begin
				sat_val[k] = 32'sh80000000;
				sat_hit[k] = 1'b1;
			end else begin
				sat_val[k] = acc_q[k][31:0];
				sat_hit[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			if (err_q) begin
				sx_q <= '0;
				sy_q <= '0;
				sz_q <= '0;
				status_q <= qwvs_pkg::ST_RANGE;
			end else begin
				sx_q <= sat_val[0];
				sy_q <= sat_val[1];
				sz_q <= sat_val[2];
				status_q <= (|sat_hit) ? qwvs_pkg::ST_SAT : qwvs_pkg::ST_OK;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.skin_x = sx_q;
	assign rsp.skin_y = sy_q;
	assign rsp.skin_z = sz_q;
	assign rsp.status = status_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("State register is not one-hot.");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == qwvs_pkg::ST_RANGE |->
		rsp.skin_x == 32'sd0 && rsp.skin_y == 32'sd0 && rsp.skin_z == 32'sd0)
		else $error("Range error result carries a nonzero vertex.");

	a_sqrt_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == S_SQRT)
		else $error("Square root finished outside the joint load wait.");

	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_free |=> rsp.valid && state_q == S_IDLE)
		else $error("Finished compute request did not reach the output register.");
endmodule

[tb/testbench.sv]
// Self-checking testbench for the quaternion weighted vertex skinning unit.
module testbench;

	typedef struct packed {
		logic [1:0] func;
		logic [9:0] slot;
		logic [5:0] joint_ref;
		logic [15:0] bias;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
		logic [4:0] weight_count;
	} request_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [1:0] status;
	} vertex_t;

	typedef struct {
		request_t r;
		bit typed;
		vertex_t v;
	} row_t;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 1750;
	localparam logic [1:0] FN_RESERVED = 2'd3;

	logic clk;
	logic arst_n;
	qwvs_req_if req ();
	qwvs_rsp_if rsp ();

	quaternion_weighted_vertex_skinning_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	longint jpos [qwvs_pkg::MAX_JOINTS][3];
	longint jquat [qwvs_pkg::MAX_JOINTS][4];
	bit joint_loaded [qwvs_pkg::MAX_JOINTS];
	bit [5:0] wjoint [qwvs_pkg::MAX_WEIGHTS];
	longint wbias [qwvs_pkg::MAX_WEIGHTS];
	longint woff [qwvs_pkg::MAX_WEIGHTS][3];
	bit weight_loaded [qwvs_pkg::MAX_WEIGHTS];

	vertex_t pending_vertices[$];
	row_t directed[$];
	int errors = 0;
	int vertices_seen = 0;
	int range_seen = 0;
	int sat_seen = 0;
	int idle_cycles = 0;
	bit burst = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint rshift_round(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint floor_root(longint t);
		longint r, c;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			c = r | (longint'(1) << b);
			if (c * c <= t)
				r = c;
		end
		return r;
	endfunction

	function automatic vertex_t skin_vertex(int unsigned start, int unsigned cnt);
		vertex_t o;
		longint acc [3];
		longint v [3], c1 [3], c2 [3], p [3];
		longint ux, uy, uz, qw, a;
		int j;
		o = '0;
		acc = '{0, 0, 0};
		if (cnt > qwvs_pkg::MAX_PER_VERTEX || start + cnt > qwvs_pkg::MAX_WEIGHTS) begin
			o.status = qwvs_pkg::ST_RANGE;
			return o;
		end
		for (int unsigned i = 0; i < cnt; i++) begin
			j = int'(wjoint[start + i]);
			ux = jquat[j][0];
			uy = jquat[j][1];
			uz = jquat[j][2];
			qw = jquat[j][3];
			for (int k = 0; k < 3; k++)
				v[k] = woff[start + i][k];
			c1[0] = rshift_round(uy * v[2] - uz * v[1], 15);
			c1[1] = rshift_round(uz * v[0] - ux * v[2], 15);
			c1[2] = rshift_round(ux * v[1] - uy * v[0], 15);
			c2[0] = uy * c1[2] - uz * c1[1];
			c2[1] = uz * c1[0] - ux * c1[2];
			c2[2] = ux * c1[1] - uy * c1[0];
			for (int k = 0; k < 3; k++) begin
				p[k] = jpos[j][k] + v[k] + rshift_round(qw * c1[k] + c2[k], 14);
				acc[k] += rshift_round(p[k] * wbias[start + i], 15);
			end
		end
		o.status = qwvs_pkg::ST_OK;
		for (int k = 0; k < 3; k++) begin
			a = acc[k];
			if (a > 64'sd2147483647) begin
				a = 64'sd2147483647;
				o.status = qwvs_pkg::ST_SAT;
			end else if (a < -64'sd2147483648) begin
				a = -64'sd2147483648;
				o.status = qwvs_pkg::ST_SAT;
			end
			if (k == 0)
				o.x = a[31:0];
			else if (k == 1)
				o.y = a[31:0];
			else
				o.z = a[31:0];
		end
		return o;
	endfunction

	// Updates the tables for a load; returns 1 with the vertex for a compute.
	function automatic bit apply_request(request_t r, output vertex_t o);
		longint x, y, z, t;
		o = '0;
		if (r.func == qwvs_pkg::FN_LOAD_JOINT && r.slot < qwvs_pkg::MAX_JOINTS) begin
			x = longint'(r.rot_x);
			y = longint'(r.rot_y);
			z = longint'(r.rot_z);
			t = (longint'(1) << 30) - x * x - y * y - z * z;
			jpos[r.slot] = '{longint'(r.pos_x), longint'(r.pos_y), longint'(r.pos_z)};
			jquat[r.slot] = '{x, y, z, (t < 0) ? longint'(0) : -floor_root(t)};
			joint_loaded[r.slot] = 1;
		end else if (r.func == qwvs_pkg::FN_LOAD_WEIGHT) begin
			wjoint[r.slot] = r.joint_ref;
			wbias[r.slot] = longint'(r.bias);
			woff[r.slot] = '{longint'(r.pos_x), longint'(r.pos_y), longint'(r.pos_z)};
			weight_loaded[r.slot] = 1;
		end else if (r.func == qwvs_pkg::FN_COMPUTE) begin
			o = skin_vertex(32'(r.slot), 32'(r.weight_count));
			return 1;
		end
		return 0;
	endfunction

	function automatic int random_gap();
		int u;
		u = int'($urandom_range(0, 99));
		if (burst || u < 55)
			return 0;
		if (u < 90)
			return int'($urandom_range(1, 3));
		return int'($urandom_range(10, 40));
	endfunction

	function automatic request_t make_req(logic [1:0] f, int s, int jr, int b,
			int px, int py, int pz, int rx, int ry, int rz, int cnt);
		request_t r;
		r.func = f;
		r.slot = 10'(s);
		r.joint_ref = 6'(jr);
		r.bias = 16'(b);
		r.pos_x = px;
		r.pos_y = py;
		r.pos_z = pz;
		r.rot_x = 16'(rx);
		r.rot_y = 16'(ry);
		r.rot_z = 16'(rz);
		r.weight_count = 5'(cnt);
		return r;
	endfunction

	function automatic void add_row(request_t r, bit typed, vertex_t v);
		row_t row;
		row.r = r;
		row.typed = typed;
		row.v = v;
		directed = {directed, row};
	endfunction

	function automatic int random_pos();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom);
		return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
	endfunction

	function automatic int random_joint();
		int j;
		do
			j = int'($urandom_range(0, qwvs_pkg::MAX_JOINTS - 1));
		while (!joint_loaded[j]);
		return j;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int u, s, cnt;
		bit ok;
		u = int'($urandom_range(0, 99));
		r = make_req(qwvs_pkg::FN_LOAD_WEIGHT, 0, 0, int'($urandom_range(0, 32768)),
			random_pos(), random_pos(), random_pos(), int'($urandom), int'($urandom),
			int'($urandom), 0);
		if (u < 20) begin
			r.func = qwvs_pkg::FN_LOAD_JOINT;
			r.slot = ($urandom_range(0, 9) == 0)
				? 10'($urandom_range(qwvs_pkg::MAX_JOINTS, 1023))
				: 10'($urandom_range(0, qwvs_pkg::MAX_JOINTS - 1));
			r.joint_ref = 6'($urandom);
			r.weight_count = 5'($urandom);
		end else if (u < 55) begin
			r.slot = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
				: 10'($urandom_range(0, 47));
			r.joint_ref = 6'(random_joint());
		end else if (u < 96) begin
			r.func = qwvs_pkg::FN_COMPUTE;
			r.joint_ref = 6'($urandom);
			if ($urandom_range(0, 9) == 0) begin
				cnt = int'($urandom_range(0, 31));
				s = (cnt > qwvs_pkg::MAX_PER_VERTEX) ? int'($urandom_range(0, 1023))
					: int'($urandom_range(qwvs_pkg::MAX_WEIGHTS - cnt + 1, 1023));
			end else begin
				ok = 0;
				for (int tries = 0; tries < 30 && !ok; tries++) begin
					cnt = int'($urandom_range(1, qwvs_pkg::MAX_PER_VERTEX));
					s = ($urandom_range(0, 3) == 0)
						? int'($urandom_range(0, qwvs_pkg::MAX_WEIGHTS - cnt))
						: int'($urandom_range(0, 48 - cnt));
					ok = 1;
					for (int i = 0; i < cnt; i++)
						if (!weight_loaded[s + i])
							ok = 0;
				end
				if (!ok)
					cnt = 0;
			end
			r.slot = 10'(s);
			r.weight_count = 5'(cnt);
		end else begin
			r.func = FN_RESERVED;
			r.slot = 10'($urandom);
			r.weight_count = 5'($urandom);
		end
		return r;
	endfunction

	task automatic send_request(request_t r, bit typed, vertex_t tv);
		vertex_t o;
		int gap;
		gap = random_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= r.func;
		req.slot <= r.slot;
		req.joint_ref <= r.joint_ref;
		req.bias <= r.bias;
		req.pos_x <= r.pos_x;
		req.pos_y <= r.pos_y;
		req.pos_z <= r.pos_z;
		req.rot_x <= r.rot_x;
		req.rot_y <= r.rot_y;
		req.rot_z <= r.rot_z;
		req.weight_count <= r.weight_count;
		do
			@(posedge clk);
		while (!req.ready);
		if (apply_request(r, o))
			pending_vertices = {pending_vertices, (typed ? tv : o)};
	endtask

	initial begin
		vertex_t z, v;
		request_t r;
		int counted;
		z = '0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = qwvs_pkg::FN_LOAD_JOINT;
		req.slot = '0;
		req.joint_ref = '0;
		req.bias = '0;
		req.pos_x = '0;
		req.pos_y = '0;
		req.pos_z = '0;
		req.rot_x = '0;
		req.rot_y = '0;
		req.rot_z = '0;
		req.weight_count = '0;
		rsp.ready = 1'b0;

		v = z;
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, v);
		v.status = qwvs_pkg::ST_RANGE;
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 17), 1, v);
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 1023, 63, 32768, -1, -1, -1, -1, -1, -1, 31),
			1, v);
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 1020, 0, 0, 0, 0, 0, 0, 0, 0, 5), 1, v);
		add_row(make_req(qwvs_pkg::FN_LOAD_JOINT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(make_req(qwvs_pkg::FN_LOAD_JOINT, 63, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32767, 0, 0, 0), 0, z);
		add_row(make_req(qwvs_pkg::FN_LOAD_JOINT, 62, 0, 0, 32'h80000000, 32'h80000000,
			32'h80000000, -32768, -32768, -32768, 0), 0, z);
		add_row(make_req(qwvs_pkg::FN_LOAD_JOINT, 64, 5, 9, 1, 2, 3, 4, 5, 6, 7), 0, z);
		add_row(make_req(qwvs_pkg::FN_LOAD_JOINT, 1023, 0, 0, 1, 2, 3, 4, 5, 6, 7), 0, z);
		add_row(make_req(FN_RESERVED, 1023, 63, 65535, -1, -1, -1, -1, -1, -1, 31), 0, z);
		add_row(make_req(qwvs_pkg::FN_LOAD_WEIGHT, 0, 0, 32768, 65536, 131072, -65536,
			0, 0, 0, 0), 0, z);
		v = '{32'sd65536, 32'sd131072, -32'sd65536, qwvs_pkg::ST_OK};
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1, v);
		add_row(make_req(qwvs_pkg::FN_LOAD_WEIGHT, 1, 63, 32768, 12345, -54321, 99999,
			0, 0, 0, 0), 0, z);
		add_row(make_req(qwvs_pkg::FN_LOAD_WEIGHT, 2, 62, 0, -7, 7, 32'h7FFFFFFF,
			0, 0, 0, 0), 0, z);
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 2), 0, z);
		add_row(make_req(qwvs_pkg::FN_LOAD_WEIGHT, 3, 63, 32768, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 0, 0, 0, 0), 0, z);
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, z);
		add_row(make_req(qwvs_pkg::FN_LOAD_WEIGHT, 4, 62, 32768, 32'h80000000, 32'h80000000,
			32'h80000000, 0, 0, 0, 0), 0, z);
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 4, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, z);
		add_row(make_req(qwvs_pkg::FN_LOAD_WEIGHT, 1023, 0, 16384, -65536, 65536, 0,
			0, 0, 0, 0), 0, z);
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, z);
		add_row(make_req(qwvs_pkg::FN_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5), 0, z);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_request(directed[i].r, directed[i].typed, directed[i].v);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (counted % 150 == 0)
				burst = ($urandom_range(0, 2) == 0);
			r = random_request();
			send_request(r, 0, z);
			counted++;
		end
		req.valid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d directed and %0d random requests, %0d vertices checked.",
			directed.size(), RANDOM_ITEMS, vertices_seen);
		$display("Vertices with range errors: %0d, saturated vertices: %0d.",
			range_seen, sat_seen);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			gap = random_gap();
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		vertex_t e;
		if (rsp.valid && rsp.ready) begin
			vertices_seen++;
			if (pending_vertices.size() == 0) begin
				$error("Unexpected vertex result x=%0d y=%0d z=%0d status=%0d",
					rsp.skin_x, rsp.skin_y, rsp.skin_z, rsp.status);
				errors++;
			end else begin
				e = pending_vertices.pop_front();
				if (e.status == qwvs_pkg::ST_RANGE)
					range_seen++;
				if (e.status == qwvs_pkg::ST_SAT)
					sat_seen++;
				if (rsp.skin_x !== e.x) begin
					$error("skin_x expected %0d actual %0d", e.x, rsp.skin_x);
					errors++;
				end
				if (rsp.skin_y !== e.y) begin
					$error("skin_y expected %0d actual %0d", e.y, rsp.skin_y);
					errors++;
				end
				if (rsp.skin_z !== e.z) begin
					$error("skin_z expected %0d actual %0d", e.z, rsp.skin_z);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired with %0d vertices outstanding.",
				pending_vertices.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

endmodule

[files.f]
rtl/core/qwvs_pkg.sv
rtl/core/qwvs_if.sv
rtl/core/qwvs_ram.sv
rtl/core/qwvs_isqrt.sv
rtl/core/quaternion_weighted_vertex_skinning_unit.sv
tb/testbench.sv
